[rtl/tfr_pkg.sv]
package tfr_pkg;

  // Frame bytes
  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'hAF;
  localparam logic [7:0] FUNC_LIMIT  = 8'hF1;
  localparam logic [7:0] LEN_LIMIT   = 8'd50;

  // Function codes
  localparam logic [7:0] FN_RATE     = 8'h10;
  localparam logic [7:0] FN_ANGLE    = 8'h11;
  localparam logic [7:0] FN_HEIGHT   = 8'h12;
  localparam logic [7:0] FN_ACK_LAST = 8'h15;

  // Acknowledge frame
  localparam logic [7:0] ACK_TAG      = 8'hEF;
  localparam logic [7:0] ACK_LEN      = 8'h02;
  localparam logic [7:0] ACK_SUM_BASE =
    8'(SYNC_FIRST + SYNC_FIRST + ACK_TAG + ACK_LEN);
  localparam logic [2:0] ACK_LAST_POS = 3'd6;

  // Gain slot bases
  localparam logic [4:0] BASE_RATE   = 5'd0;
  localparam logic [4:0] BASE_ANGLE  = 5'd9;
  localparam logic [4:0] BASE_HEIGHT = 5'd18;
  localparam logic [3:0] CNT_FULL    = 4'd9;
  localparam logic [3:0] CNT_HEIGHT  = 4'd6;

  localparam int PAYLOAD_DEPTH_DEF = 64;
  localparam int CNT_W             = 6;  // payload byte counter
  localparam int RD_W              = 5;  // gain bytes live in slots 0..17

  localparam logic OUT_ACK  = 1'b0;
  localparam logic OUT_GAIN = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_GOT_AA  = 3'd1,
    PH_GOT_AF  = 3'd2,
    PH_GOT_FN  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_TRAIL   = 3'd5
  } parse_phase_e;

  typedef enum logic [2:0] {
    EM_IDLE,
    EM_RD_HI,
    EM_RD_LO,
    EM_PUSH_GAIN,
    EM_ACK
  } emit_state_e;

  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] idx;
    logic [7:0]       data;
  } tfr_wr_t;

  typedef struct packed {
    logic            en;
    logic [RD_W-1:0] addr;
  } tfr_rd_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] func;
    logic [7:0] sum;
  } tfr_start_t;

  function automatic logic [3:0] gain_count(input logic [7:0] func);
    logic [3:0] n;
    n = 4'd0;
    if (func == FN_RATE || func == FN_ANGLE) n = CNT_FULL;
    else if (func == FN_HEIGHT)              n = CNT_HEIGHT;
    return n;
  endfunction

  function automatic logic [4:0] gain_base(input logic [7:0] func);
    logic [4:0] b;
    b = BASE_RATE;
    if (func == FN_ANGLE)       b = BASE_ANGLE;
    else if (func == FN_HEIGHT) b = BASE_HEIGHT;
    return b;
  endfunction

endpackage

[rtl/tfr_rx_if.sv]
interface tfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/tfr_res_if.sv]
interface tfr_res_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  tx_byte;
  logic [4:0]  gain_index;
  logic [15:0] gain_value;
  logic        last_of_run;

  modport source (output valid, output out_kind, output tx_byte, output gain_index,
                  output gain_value, output last_of_run, input ready);
  modport sink   (input valid, input out_kind, input tx_byte, input gain_index,
                  input gain_value, input last_of_run, output ready);
endinterface

[rtl/tfr_store.sv]
module tfr_store #(
  parameter int PAYLOAD_DEPTH = tfr_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tfr_pkg::tfr_wr_t wr_i,
  input  tfr_pkg::tfr_rd_t rd_i,
  output logic [7:0]      rd_data_o
);

  localparam int AW = $clog2(PAYLOAD_DEPTH);

  logic [7:0]               mem [PAYLOAD_DEPTH];
  logic [PAYLOAD_DEPTH-1:0] vld_q;
  logic [7:0]               rd_data_q;
  logic                     rd_vld_q;
  logic                     wr_ok;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;

  // writes past the end of the store are dropped
  assign wr_ok   = wr_i.en && (32'(wr_i.idx) < PAYLOAD_DEPTH);
  assign wr_addr = AW'(wr_i.idx);
  assign rd_addr = AW'(rd_i.addr);

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[wr_addr] <= wr_i.data;
    end
  end

  // per-entry written flags; an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_ok) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  // registered read, held between reads
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (rd_i.en) begin
      rd_vld_q <= vld_q[rd_addr];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : 8'd0;

endmodule

[rtl/tfr_parser.sv]
module tfr_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  tfr_rx_if.sink             rx_i,
  input  logic               busy_i,
  output tfr_pkg::tfr_wr_t   wr_o,
  output tfr_pkg::tfr_start_t start_o
);

  tfr_pkg::parse_phase_e    phase_q, phase_d;
  logic [7:0]               func_q, func_d;
  logic [tfr_pkg::CNT_W-1:0] remain_q, remain_d;
  logic [tfr_pkg::CNT_W-1:0] count_q, count_d;
  logic [7:0]               sum_q, sum_d;
  logic                     accept;
  logic [7:0]               b;

  assign rx_i.ready = !busy_i;
  assign accept     = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= tfr_pkg::PH_IDLE;
      func_q   <= '0;
      remain_q <= '0;
      count_q  <= '0;
      sum_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      func_q   <= func_d;
      remain_q <= remain_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
    end
  end

  // frame sequencing; any byte that does not fit drops back to idle
  always_comb begin
    phase_d  = phase_q;
    func_d   = func_q;
    remain_d = remain_q;
    count_d  = count_q;
    sum_d    = sum_q;
    wr_o     = '0;
    start_o  = '0;
    if (accept) begin
      phase_d = tfr_pkg::PH_IDLE;
      unique case (phase_q)
        tfr_pkg::PH_IDLE: begin
          if (b == tfr_pkg::SYNC_FIRST) begin
            phase_d = tfr_pkg::PH_GOT_AA;
            sum_d   = b;
          end
        end
        tfr_pkg::PH_GOT_AA: begin
          if (b == tfr_pkg::SYNC_SECOND) begin
            phase_d = tfr_pkg::PH_GOT_AF;
            sum_d   = sum_q + b;
          end
        end
        tfr_pkg::PH_GOT_AF: begin
          if (b < tfr_pkg::FUNC_LIMIT) begin
            phase_d = tfr_pkg::PH_GOT_FN;
            func_d  = b;
            sum_d   = sum_q + b;
          end
        end
        tfr_pkg::PH_GOT_FN: begin
          if (b < tfr_pkg::LEN_LIMIT) begin
            phase_d  = tfr_pkg::PH_PAYLOAD;
            remain_d = b[tfr_pkg::CNT_W-1:0];
            count_d  = '0;
            sum_d    = sum_q + b;
          end
        end
        tfr_pkg::PH_PAYLOAD: begin
          if (remain_q != '0) begin
            remain_d  = remain_q - 1'b1;
            count_d   = count_q + 1'b1;
            sum_d     = sum_q + b;
            wr_o.en   = 1'b1;
            wr_o.idx  = count_q;
            wr_o.data = b;
            phase_d   = (remain_q == tfr_pkg::CNT_W'(1)) ? tfr_pkg::PH_TRAIL
                                                         : tfr_pkg::PH_PAYLOAD;
          end
        end
        tfr_pkg::PH_TRAIL: begin
          // trailing byte is stored too but never checked
          wr_o.en       = 1'b1;
          wr_o.idx      = count_q;
          wr_o.data     = b;
          start_o.valid = (func_q >= tfr_pkg::FN_RATE) && (func_q <= tfr_pkg::FN_ACK_LAST);
          start_o.func  = func_q;
          start_o.sum   = sum_q;
        end
        default: begin
          phase_d = tfr_pkg::PH_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/tfr_emitter.sv]
module tfr_emitter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfr_pkg::tfr_start_t start_i,
  output logic                busy_o,
  output tfr_pkg::tfr_rd_t    rd_o,
  input  logic [7:0]          rd_data_i,
  tfr_res_if.source           res_o
);

  tfr_pkg::emit_state_e state_q, state_d;
  logic [7:0]  func_q, func_d;
  logic [7:0]  sum_q, sum_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [3:0]  idx_q, idx_d;
  logic [4:0]  base_q, base_d;
  logic [2:0]  pos_q, pos_d;
  logic [7:0]  hi_q, hi_d;

  logic        out_vld_q, out_vld_d;
  logic        kind_q, kind_d;
  logic [7:0]  tx_q, tx_d;
  logic [4:0]  gidx_q, gidx_d;
  logic [15:0] gval_q, gval_d;
  logic        last_q, last_d;

  logic        slot_free;
  logic        load;
  logic [7:0]  ack_byte;

  assign slot_free = !out_vld_q || res_o.ready;
  assign busy_o    = (state_q != tfr_pkg::EM_IDLE);

  // acknowledge byte at the current position
  always_comb begin
    unique case (pos_q)
      3'd0, 3'd1: ack_byte = tfr_pkg::SYNC_FIRST;
      3'd2:       ack_byte = tfr_pkg::ACK_TAG;
      3'd3:       ack_byte = tfr_pkg::ACK_LEN;
      3'd4:       ack_byte = func_q;
      3'd5:       ack_byte = sum_q;
      3'd6:       ack_byte = 8'(tfr_pkg::ACK_SUM_BASE + func_q + sum_q);
      default:    ack_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tfr_pkg::EM_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    sum_q  <= sum_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    base_q <= base_d;
    pos_q  <= pos_d;
    hi_q   <= hi_d;
    kind_q <= kind_d;
    tx_q   <= tx_d;
    gidx_q <= gidx_d;
    gval_q <= gval_d;
    last_q <= last_d;
  end

  // gain reads (high byte, low byte, push) then the acknowledge bytes
  always_comb begin
    state_d = state_q;
    func_d  = func_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    base_d  = base_q;
    pos_d   = pos_q;
    hi_d    = hi_q;
    kind_d  = kind_q;
    tx_d    = tx_q;
    gidx_d  = gidx_q;
    gval_d  = gval_q;
    last_d  = last_q;
    rd_o    = '0;
    load    = 1'b0;
    unique case (state_q)
      tfr_pkg::EM_IDLE: begin
        if (start_i.valid) begin
          func_d  = start_i.func;
          sum_d   = start_i.sum;
          cnt_d   = tfr_pkg::gain_count(start_i.func);
          base_d  = tfr_pkg::gain_base(start_i.func);
          idx_d   = '0;
          pos_d   = '0;
          state_d = (tfr_pkg::gain_count(start_i.func) != '0) ? tfr_pkg::EM_RD_HI
                                                              : tfr_pkg::EM_ACK;
        end
      end
      tfr_pkg::EM_RD_HI: begin
        rd_o.en   = 1'b1;
        rd_o.addr = {idx_q, 1'b0};
        state_d   = tfr_pkg::EM_RD_LO;
      end
      tfr_pkg::EM_RD_LO: begin
        rd_o.en   = 1'b1;
        rd_o.addr = {idx_q, 1'b1};
        hi_d      = rd_data_i;
        state_d   = tfr_pkg::EM_PUSH_GAIN;
      end
      tfr_pkg::EM_PUSH_GAIN: begin
        if (slot_free) begin
          load   = 1'b1;
          kind_d = tfr_pkg::OUT_GAIN;
          tx_d   = 8'd0;
          gidx_d = base_q + 5'(idx_q);
          gval_d = {hi_q, rd_data_i};
          last_d = 1'b0;
          idx_d  = idx_q + 1'b1;
          state_d = (idx_q + 1'b1 == cnt_q) ? tfr_pkg::EM_ACK : tfr_pkg::EM_RD_HI;
        end
      end
      tfr_pkg::EM_ACK: begin
        if (slot_free) begin
          load   = 1'b1;
          kind_d = tfr_pkg::OUT_ACK;
          tx_d   = ack_byte;
          gidx_d = 5'd0;
          gval_d = 16'd0;
          last_d = (pos_q == tfr_pkg::ACK_LAST_POS);
          pos_d  = pos_q + 1'b1;
          if (pos_q == tfr_pkg::ACK_LAST_POS) begin
            state_d = tfr_pkg::EM_IDLE;
          end
        end
      end
      default: begin
        state_d = tfr_pkg::EM_IDLE;
      end
    endcase
    out_vld_d = load ? 1'b1 : (res_o.ready ? 1'b0 : out_vld_q);
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.out_kind    = kind_q;
  assign res_o.tx_byte     = tx_q;
  assign res_o.gain_index  = gidx_q;
  assign res_o.gain_value  = gval_q;
  assign res_o.last_of_run = last_q;

  // a new frame only starts while the emitter is free
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i.valid |-> state_q == tfr_pkg::EM_IDLE)
    else $error("frame start while emitter busy");

  // the final acknowledge byte closes the run
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last_d) |=> state_q == tfr_pkg::EM_IDLE)
    else $error("emitter still running after last result");

  // gain writes stay inside the slot map
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && kind_q == tfr_pkg::OUT_GAIN) |-> (gidx_q <= 5'd23 && !last_q))
    else $error("gain write out of range or marked last");

endmodule

[rtl/tuning_frame_receiver.sv]
// Tuning frame receiver: parses AA AF <function> <length> <payload> <trailer> frames from a
// byte stream and keeps a running 8-bit sum (trailer not compared). A trailing byte on
// functions 0x10/0x11/0x12 produces 9/9/6 gain writes (big-endian payload pairs, slots 0-8,
// 9-17, 18-23); functions 0x10-0x15 then produce a 7-byte acknowledge AA AA EF 02 fn sum chk,
// the last result flagged by last_of_run. Ordinary bytes are taken one per cycle. After a
// result-producing trailer the input is held off while results are generated: each gain
// takes two reads through the single payload memory read port and then the push, each
// acknowledge byte one push, and any output stall lengthens the hold-off. The next
// byte can be taken as soon as the last result sits in the output register. The payload
// memory comes out of reset reading zero through per-entry written flags; no clearing pass.
module tuning_frame_receiver #(
  parameter int PAYLOAD_DEPTH = tfr_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tfr_rx_if.sink    rx_i,
  tfr_res_if.source res_o
);

  tfr_pkg::tfr_wr_t    wr;
  tfr_pkg::tfr_rd_t    rd;
  tfr_pkg::tfr_start_t start;
  logic                busy;
  logic [7:0]          rd_data;

  tfr_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .busy_i  (busy),
    .wr_o    (wr),
    .start_o (start)
  );

  tfr_store #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_i      (rd),
    .rd_data_o (rd_data)
  );

  tfr_emitter u_emitter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .busy_o    (busy),
    .rd_o      (rd),
    .rd_data_i (rd_data),
    .res_o     (res_o)
  );

endmodule
